### hdl/utf8_stream_decoder_core_assert.svh
// Assertion macros for the UTF-8 stream decoder.
// Both expect clk_i and rst_ni in scope.
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define U8D_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("u8d: assertion failed");

// Next-cycle implication.
`define U8D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("u8d: assertion failed");

`endif

### hdl/u8d_pkg.sv
package u8d_pkg;

  localparam int unsigned CpW      = 31;
  localparam int unsigned LenW     = 3;
  localparam int unsigned PayW     = 7;
  localparam int unsigned ContPayW = 6;
  localparam int unsigned FifoDepth = 2;

  typedef enum logic [1:0] {
    KIND_ASCII = 2'd0,
    KIND_CONT  = 2'd1,
    KIND_LEAD  = 2'd2
  } byte_kind_e;

  // One classified byte as it sits in the queue.
  typedef struct packed {
    byte_kind_e        kind;
    logic [LenW-1:0]   len;
    logic [PayW-1:0]   payload;
  } byte_class_t;

  // Read side of the queue.
  typedef struct packed {
    logic        valid;
    byte_class_t data;
  } fifo_rd_t;

  // Write side of the queue.
  typedef struct packed {
    logic        push;
    byte_class_t data;
  } fifo_wr_t;

endpackage

### hdl/u8d_front.sv
module u8d_front import u8d_pkg::*; (
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       fifo_full_i,
  output logic       in_ready_o,
  output fifo_wr_t   wr_o
);

  byte_class_t cls;

  always_comb begin
    cls.kind    = KIND_LEAD;
    cls.len     = LenW'(1);
    cls.payload = '0;
    unique casez (in_byte_i)
      8'b0???????: begin
        cls.kind    = KIND_ASCII;
        cls.payload = in_byte_i[6:0];
      end
      8'b10??????: begin
        cls.kind    = KIND_CONT;
        cls.payload = PayW'(in_byte_i[5:0]);
      end
      8'b110?????: begin
        cls.len     = LenW'(2);
        cls.payload = PayW'(in_byte_i[4:0]);
      end
      8'b1110????: begin
        cls.len     = LenW'(3);
        cls.payload = PayW'(in_byte_i[3:0]);
      end
      8'b11110???: begin
        cls.len     = LenW'(4);
        cls.payload = PayW'(in_byte_i[2:0]);
      end
      8'b111110??: begin
        cls.len     = LenW'(5);
        cls.payload = PayW'(in_byte_i[1:0]);
      end
      default: begin
        // 0xFC..0xFF all open a six-byte form
        cls.len     = LenW'(6);
        cls.payload = PayW'(in_byte_i[0]);
      end
    endcase
  end

  assign in_ready_o = !fifo_full_i;
  assign wr_o.push  = in_valid_i && !fifo_full_i;
  assign wr_o.data  = cls;

endmodule

### hdl/u8d_fifo.sv
`include "utf8_stream_decoder_core_assert.svh"

module u8d_fifo import u8d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fifo_wr_t wr_i,
  input  logic     pop_i,
  output fifo_rd_t rd_o,
  output logic     full_o
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  byte_class_t     mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign full_o     = (count_q == CntW'(FifoDepth));
  assign push       = wr_i.push && !full_o;
  assign pop        = pop_i && (count_q != '0);
  assign rd_o.valid = (count_q != '0);
  assign rd_o.data  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_i.data;
    end
  end

  `U8D_ASSERT_NOW(a_cnt_bound, 1'b1, count_q <= CntW'(FifoDepth))
  `U8D_ASSERT_NEXT(a_cnt_up, push && !pop, count_q == $past(count_q) + CntW'(1))
  `U8D_ASSERT_NEXT(a_cnt_down, pop && !push, count_q == $past(count_q) - CntW'(1))

endmodule

### hdl/u8d_back.sv
`include "utf8_stream_decoder_core_assert.svh"

module u8d_back import u8d_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fifo_rd_t        rd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CpW-1:0]  code_point_o,
  output logic [LenW-1:0] seq_length_o,
  output logic            bad_sequence_o
);

  logic [LenW-1:0] rem_q, rem_d;
  logic [CpW-1:0]  part_q, part_d;
  logic [LenW-1:0] tot_q, tot_d;
  logic            out_valid_q, out_valid_d;
  logic [CpW-1:0]  cp_q;
  logic [LenW-1:0] len_q;
  logic            bad_q;

  logic            advance;
  logic            emit;
  logic [CpW-1:0]  emit_cp;
  logic [LenW-1:0] emit_len;
  logic            emit_bad;
  logic [CpW-1:0]  acc;

  // Output slot is free or being drained this cycle.
  assign advance = rd_i.valid && (!out_valid_q || out_ready_i);
  assign pop_o   = advance;
  assign acc     = {part_q[CpW-ContPayW-1:0], rd_i.data.payload[ContPayW-1:0]};

  always_comb begin
    rem_d    = rem_q;
    part_d   = part_q;
    tot_d    = tot_q;
    emit     = 1'b0;
    emit_cp  = '0;
    emit_len = '0;
    emit_bad = 1'b0;
    if (advance) begin
      if (rem_q == '0) begin
        unique case (rd_i.data.kind)
          KIND_ASCII: begin
            emit     = 1'b1;
            emit_cp  = CpW'(rd_i.data.payload);
            emit_len = LenW'(1);
          end
          KIND_LEAD: begin
            part_d = CpW'(rd_i.data.payload);
            tot_d  = rd_i.data.len;
            rem_d  = rd_i.data.len - LenW'(1);
          end
          default: begin
            // stray continuation
            emit     = 1'b1;
            emit_bad = 1'b1;
          end
        endcase
      end else if (rd_i.data.kind != KIND_CONT) begin
        // broken sequence: drop partial and this byte
        emit     = 1'b1;
        emit_bad = 1'b1;
        rem_d    = '0;
        part_d   = '0;
        tot_d    = '0;
      end else if (rem_q == LenW'(1)) begin
        emit     = 1'b1;
        emit_cp  = acc;
        emit_len = tot_q;
        rem_d    = '0;
        part_d   = '0;
        tot_d    = '0;
      end else begin
        part_d = acc;
        rem_d  = rem_q - LenW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    tot_q  <= tot_d;
    if (advance && emit) begin
      cp_q  <= emit_cp;
      len_q <= emit_len;
      bad_q <= emit_bad;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_point_o   = cp_q;
  assign seq_length_o   = len_q;
  assign bad_sequence_o = bad_q;

  `U8D_ASSERT_NOW(a_err_zero, out_valid_q && bad_q, cp_q == '0 && len_q == '0)
  `U8D_ASSERT_NOW(a_ok_len, out_valid_q && !bad_q, len_q != '0 && len_q <= LenW'(6))
  `U8D_ASSERT_NOW(a_rem_lt_tot, rem_q != '0, tot_q > rem_q && rem_q <= LenW'(5))
  `U8D_ASSERT_NEXT(a_hold, !advance, rem_q == $past(rem_q))

endmodule

### hdl/utf8_stream_decoder_core.sv
// UTF-8 stream decoder, original one- to six-byte forms.
// Input channel: one raw byte per transfer on in_byte_i (in_valid_i/in_ready_o).
// Output channel: one result per transfer (out_valid_o/out_ready_i) carrying
//   code_point_o, seq_length_o and bad_sequence_o. A lead byte alone gives no
//   result; an ASCII byte or the final continuation byte gives a character;
//   a stray or misplaced byte gives an error result with zero value and length.
// Overlong forms are decoded as they stand; 0xFE/0xFF open six-byte forms.
// Throughput: one byte per cycle, sustained, with out_ready_i held high.
// Result path: the completing byte is written into the two-entry queue; the
//   back takes it from there and the output register captures the result.
// Structure: the front classifies each byte into the queue; the back runs the
//   sequence state and owns the output register, so either side can stall.
// Stall: with out_ready_i low the output holds; the queue then fills and
//   in_ready_o falls after at most two more bytes.
// Reset (rst_ni low, asynchronous): queue empty, decoder idle, no result
//   pending; any partial sequence is discarded.
module utf8_stream_decoder_core import u8d_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CpW-1:0]  code_point_o,
  output logic [LenW-1:0] seq_length_o,
  output logic            bad_sequence_o
);

  fifo_wr_t wr;
  fifo_rd_t rd;
  logic     fifo_full;
  logic     pop;

  // front: byte classification
  u8d_front u_front (
    .in_valid_i  (in_valid_i),
    .in_byte_i   (in_byte_i),
    .fifo_full_i (fifo_full),
    .in_ready_o  (in_ready_o),
    .wr_o        (wr)
  );

  // decoupling queue
  u8d_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .pop_i  (pop),
    .rd_o   (rd),
    .full_o (fifo_full)
  );

  // back: sequence assembly and output register
  u8d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rd_i           (rd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_point_o   (code_point_o),
    .seq_length_o   (seq_length_o),
    .bad_sequence_o (bad_sequence_o)
  );

endmodule
